// ----- rtl/rtc3w_pkg.sv -----
`default_nettype none

package rtc3w_pkg;

    localparam int BurstBytesDefault = 8;
    localparam logic [7:0] RamThresholdReset = 8'd192;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_CMD,
        PH_WRITE,
        PH_READ
    } phase_t;

    typedef enum logic [1:0] {
        OP_WRITE,
        OP_READ,
        OP_BURST
    } op_t;

    typedef struct packed {
        logic       start_req;
        logic [1:0] op;
        logic [7:0] address;
        logic [7:0] write_value;
        logic       io_in;
    } req_t;

    typedef struct packed {
        logic       chip_enable;
        logic       serial_clock;
        logic       io_out;
        logic       io_drive;
        logic [7:0] read_value;
        logic       read_valid;
        logic       read_last;
        logic       busy_res;
    } rsp_t;

    // divide by ten through the reciprocal 205/2048, exact for 8-bit values
    function automatic logic [7:0] to_bcd(input logic [7:0] v);
        logic [15:0] prod;
        logic [4:0]  q;
        logic [7:0]  r;
        prod = {8'd0, v} * 16'd205;
        q    = prod[15:11];
        r    = v - ({3'd0, q} * 8'd10);
        return {q[3:0], r[3:0]};
    endfunction

    function automatic logic [7:0] from_bcd(input logic [7:0] v);
        logic [7:0] hi;
        hi = {4'd0, v[7:4]};
        return (hi << 3) + (hi << 1) + {4'd0, v[3:0]};
    endfunction

endpackage

`default_nettype wire

// ----- rtl/rtc_three_wire_serial_master.sv -----
// three-wire real-time-clock bus master, one bus tick per request transaction
// req channel: each transaction is one bit-clock tick carrying start_req, op,
//   address, write_value and the sampled io_in level
// rsp channel: one transaction per tick with the pin levels (chip_enable,
//   serial_clock, io_out, io_drive), a completed read byte with read_valid and
//   read_last, and busy_res
// a start on an idle tick runs a byte write, a byte read or a burst read of
//   BURST_BYTES bytes; every bit spans a clock-high and a clock-low tick
// response: the response to a tick is registered and appears in the cycle after its acceptance
// throughput: one tick per cycle while responses are taken, set by the single
//   state update between the state registers and the response register
// cfg_write_en/cfg_write_data load ram_threshold; addresses below it use bcd
// reset: bus idle, threshold 192, response register empty
// when the receiver stalls the response register holds and req_ready drops
//   until the held response is taken
`default_nettype none

module rtc_three_wire_serial_master #(
    parameter int BURST_BYTES = rtc3w_pkg::BurstBytesDefault
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             req_valid,
    output logic                  req_ready,
    input  wire rtc3w_pkg::req_t  req,
    output logic                  rsp_valid,
    input  wire logic             rsp_ready,
    output rtc3w_pkg::rsp_t       rsp,
    input  wire logic             cfg_write_en,
    input  wire logic [7:0]       cfg_write_data
);

    localparam int ByteW = (BURST_BYTES > 1) ? $clog2(BURST_BYTES) : 1;
    localparam logic [ByteW-1:0] LastBurst = ByteW'(BURST_BYTES - 1);

    rtc3w_pkg::phase_t phase_reg, phase_next, phase_eff;
    logic [2:0]        bit_index_reg, bit_index_next, bit_cur;
    logic [ByteW-1:0]  byte_index_reg, byte_index_next;
    logic [7:0]        shift_byte_reg, shift_byte_next, shift_eff;
    logic              clock_high_reg, clock_high_next;
    logic [1:0]        operation_reg, operation_next, operation_eff;
    logic              convert_bcd_reg, convert_bcd_next, convert_eff;
    logic [7:0]        pending_value_reg, pending_value_next, pending_eff;
    logic [7:0]        ram_threshold_reg;
    logic              rsp_valid_reg, rsp_valid_next;
    rtc3w_pkg::rsp_t   rsp_reg, rsp_next;

    logic accept;
    logic start_take;
    logic high_tick;
    logic byte_end;
    logic last_byte;

    assign req_ready = !rsp_valid_reg || rsp_ready;
    assign accept    = req_valid && req_ready;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // start handling folded into the tick that accepts it
    always_comb
    begin
        start_take = (phase_reg == rtc3w_pkg::PH_IDLE) && req.start_req
                     && (req.op inside {rtc3w_pkg::OP_WRITE, rtc3w_pkg::OP_READ,
                                        rtc3w_pkg::OP_BURST});
        if (start_take)
        begin
            phase_eff     = rtc3w_pkg::PH_CMD;
            operation_eff = req.op;
            convert_eff   = req.address < ram_threshold_reg;
            shift_eff     = (req.op == rtc3w_pkg::OP_WRITE) ? req.address
                                                            : req.address + 8'd1;
            pending_eff   = (req.address < ram_threshold_reg)
                            ? rtc3w_pkg::to_bcd(req.write_value) : req.write_value;
        end
        else
        begin
            phase_eff     = phase_reg;
            operation_eff = operation_reg;
            convert_eff   = convert_bcd_reg;
            shift_eff     = shift_byte_reg;
            pending_eff   = pending_value_reg;
        end
        bit_cur   = start_take ? 3'd0 : bit_index_reg;
        high_tick = start_take || !clock_high_reg;
        byte_end  = !high_tick && (bit_index_reg == 3'd7);
        last_byte = (operation_eff != rtc3w_pkg::OP_BURST) || (byte_index_reg == LastBurst);
    end

    // next state
    always_comb
    begin
        phase_next         = phase_eff;
        bit_index_next     = bit_cur;
        byte_index_next    = start_take ? '0 : byte_index_reg;
        shift_byte_next    = shift_eff;
        clock_high_next    = clock_high_reg;
        operation_next     = operation_eff;
        convert_bcd_next   = convert_eff;
        pending_value_next = pending_eff;
        if (phase_eff != rtc3w_pkg::PH_IDLE)
        begin
            if ((phase_eff == rtc3w_pkg::PH_READ) && high_tick && req.io_in)
            begin
                shift_byte_next = shift_eff | (8'd1 << bit_cur);
            end
            clock_high_next = high_tick;
            if (!high_tick)
            begin
                if (!byte_end)
                begin
                    bit_index_next = bit_index_reg + 3'd1;
                end
                else
                begin
                    bit_index_next = 3'd0;
                    case (phase_eff)
                        rtc3w_pkg::PH_CMD:
                        begin
                            shift_byte_next = 8'd0;
                            phase_next = (operation_eff == rtc3w_pkg::OP_WRITE)
                                         ? rtc3w_pkg::PH_WRITE : rtc3w_pkg::PH_READ;
                        end
                        rtc3w_pkg::PH_WRITE:
                        begin
                            phase_next = rtc3w_pkg::PH_IDLE;
                        end
                        rtc3w_pkg::PH_READ:
                        begin
                            shift_byte_next = 8'd0;
                            if (last_byte)
                            begin
                                byte_index_next = '0;
                                phase_next      = rtc3w_pkg::PH_IDLE;
                            end
                            else
                            begin
                                byte_index_next = byte_index_reg + ByteW'(1);
                            end
                        end
                        default:
                        begin
                            phase_next = rtc3w_pkg::PH_IDLE;
                        end
                    endcase
                end
            end
        end
    end

    // response fields
    always_comb
    begin
        rsp_next = '0;
        if (phase_eff != rtc3w_pkg::PH_IDLE)
        begin
            rsp_next.chip_enable  = 1'b1;
            rsp_next.busy_res     = 1'b1;
            rsp_next.serial_clock = high_tick;
            case (phase_eff)
                rtc3w_pkg::PH_CMD:
                begin
                    rsp_next.io_drive = 1'b1;
                    rsp_next.io_out   = shift_eff[bit_cur];
                end
                rtc3w_pkg::PH_WRITE:
                begin
                    rsp_next.io_drive = 1'b1;
                    rsp_next.io_out   = pending_eff[bit_cur];
                end
                rtc3w_pkg::PH_READ:
                begin
                    if (byte_end)
                    begin
                        rsp_next.read_valid = 1'b1;
                        rsp_next.read_last  = last_byte;
                        rsp_next.read_value = convert_eff ? rtc3w_pkg::from_bcd(shift_eff)
                                                          : shift_eff;
                    end
                end
                default:
                begin
                    rsp_next.io_drive = 1'b0;
                end
            endcase
        end
    end

    always_comb
    begin
        if (accept)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end
        else
        begin
            rsp_valid_next = rsp_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg         <= rtc3w_pkg::PH_IDLE;
            bit_index_reg     <= 3'd0;
            byte_index_reg    <= '0;
            shift_byte_reg    <= 8'd0;
            clock_high_reg    <= 1'b0;
            operation_reg     <= 2'd0;
            convert_bcd_reg   <= 1'b0;
            pending_value_reg <= 8'd0;
            ram_threshold_reg <= rtc3w_pkg::RamThresholdReset;
            rsp_valid_reg     <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                phase_reg         <= phase_next;
                bit_index_reg     <= bit_index_next;
                byte_index_reg    <= byte_index_next;
                shift_byte_reg    <= shift_byte_next;
                clock_high_reg    <= clock_high_next;
                operation_reg     <= operation_next;
                convert_bcd_reg   <= convert_bcd_next;
                pending_value_reg <= pending_value_next;
            end
            if (cfg_write_en)
            begin
                ram_threshold_reg <= cfg_write_data;
            end
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            rsp_reg <= rsp_next;
        end
    end

endmodule

`default_nettype wire

// ----- dv/testbench.sv -----
`timescale 1ns / 1ps

module testbench;

    localparam int BurstLen = rtc3w_pkg::BurstBytesDefault;
    localparam int QuietLimit = 500;
    localparam logic [1:0] OpUndefined = 2'd3;
    localparam int IoLow = 0;
    localparam int IoHigh = 1;
    localparam int IoRandom = 2;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic req_valid = 1'b0;
    logic req_ready;
    rtc3w_pkg::req_t req = '0;
    logic rsp_valid;
    logic rsp_ready = 1'b0;
    rtc3w_pkg::rsp_t rsp;
    logic cfg_write_en = 1'b0;
    logic [7:0] cfg_write_data = 8'd0;

    rtc3w_pkg::req_t tick_queue[$];
    rtc3w_pkg::rsp_t due_pins[$];
    int gap_left = 0;
    int stall_left = 0;
    int quiet_cycles = 0;
    int fail_count = 0;
    int ticks_checked = 0;
    int bytes_read = 0;
    int transfers_started = 0;
    bit quiet_run = 1'b0;

    // bus master state as predicted
    rtc3w_pkg::phase_t bus_phase = rtc3w_pkg::PH_IDLE;
    logic [2:0] bit_pos = 3'd0;
    logic [4:0] byte_pos = 5'd0;
    logic [7:0] shreg = 8'd0;
    logic sclk_high = 1'b0;
    rtc3w_pkg::op_t bus_op = rtc3w_pkg::OP_WRITE;
    logic use_bcd = 1'b0;
    logic [7:0] wr_byte = 8'd0;
    logic [7:0] ram_limit = rtc3w_pkg::RamThresholdReset;

    rtc_three_wire_serial_master #(
        .BURST_BYTES(BurstLen)
    ) i_dut (
        .clk(clk),
        .rst_n(rst_n),
        .req_valid(req_valid),
        .req_ready(req_ready),
        .req(req),
        .rsp_valid(rsp_valid),
        .rsp_ready(rsp_ready),
        .rsp(rsp),
        .cfg_write_en(cfg_write_en),
        .cfg_write_data(cfg_write_data)
    );

    always #5 clk = ~clk;

    function automatic rtc3w_pkg::rsp_t bus_tick(input rtc3w_pkg::req_t t);
        rtc3w_pkg::rsp_t r;
        logic hi_tick;
        int enc;
        int total;
        r = '0;
        if (bus_phase == rtc3w_pkg::PH_IDLE && t.start_req
            && (t.op == rtc3w_pkg::OP_WRITE || t.op == rtc3w_pkg::OP_READ
                || t.op == rtc3w_pkg::OP_BURST))
        begin
            bus_op = rtc3w_pkg::op_t'(t.op);
            use_bcd = t.address < ram_limit;
            shreg = (bus_op == rtc3w_pkg::OP_WRITE) ? t.address : t.address + 8'd1;
            enc = (t.write_value / 10) * 16 + t.write_value % 10;
            wr_byte = use_bcd ? enc[7:0] : t.write_value;
            bit_pos = 3'd0;
            byte_pos = 5'd0;
            sclk_high = 1'b0;
            bus_phase = rtc3w_pkg::PH_CMD;
            transfers_started++;
        end
        if (bus_phase != rtc3w_pkg::PH_IDLE)
        begin
            hi_tick = !sclk_high;
            r.chip_enable = 1'b1;
            r.busy_res = 1'b1;
            r.serial_clock = hi_tick;
            if (bus_phase == rtc3w_pkg::PH_CMD)
            begin
                r.io_drive = 1'b1;
                r.io_out = shreg[bit_pos];
            end
            else if (bus_phase == rtc3w_pkg::PH_WRITE)
            begin
                r.io_drive = 1'b1;
                r.io_out = wr_byte[bit_pos];
            end
            else if (hi_tick && t.io_in)
            begin
                shreg[bit_pos] = 1'b1;
            end
            sclk_high = hi_tick;
            if (!hi_tick)
            begin
                if (bit_pos != 3'd7)
                begin
                    bit_pos = bit_pos + 3'd1;
                end
                else
                begin
                    bit_pos = 3'd0;
                    case (bus_phase)
                        rtc3w_pkg::PH_CMD:
                        begin
                            shreg = 8'd0;
                            bus_phase = (bus_op == rtc3w_pkg::OP_WRITE)
                                        ? rtc3w_pkg::PH_WRITE : rtc3w_pkg::PH_READ;
                        end
                        rtc3w_pkg::PH_WRITE:
                        begin
                            bus_phase = rtc3w_pkg::PH_IDLE;
                        end
                        default:
                        begin
                            total = (bus_op == rtc3w_pkg::OP_BURST) ? BurstLen : 1;
                            r.read_value = use_bcd ? shreg[7:4] * 10 + shreg[3:0] : shreg;
                            r.read_valid = 1'b1;
                            shreg = 8'd0;
                            if (byte_pos + 1 >= total)
                            begin
                                r.read_last = 1'b1;
                                byte_pos = 5'd0;
                                bus_phase = rtc3w_pkg::PH_IDLE;
                            end
                            else
                            begin
                                byte_pos = byte_pos + 5'd1;
                            end
                        end
                    endcase
                end
            end
        end
        return r;
    endfunction

    task automatic check_field(input string name, input logic [7:0] want,
                               input logic [7:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0h, got %0h", name, want, got);
            fail_count++;
        end
    endtask

    task automatic add_tick(input logic start, input logic [1:0] op, input logic [7:0] addr,
                            input logic [7:0] wval, input logic io);
        rtc3w_pkg::req_t t;
        t = '{start, op, addr, wval, io};
        tick_queue.push_back(t);
    endtask

    // noise that can never start a transfer from idle
    task automatic add_noise_tick;
        logic [31:0] noise;
        noise = $urandom;
        add_tick(noise[0], noise[0] ? OpUndefined : noise[2:1], noise[10:3], noise[18:11],
                 noise[19]);
    endtask

    // start tick plus the following ticks up to span in total, stray starts while busy
    task automatic add_transfer(input rtc3w_pkg::op_t op, input logic [7:0] addr,
                                input logic [7:0] wval, input int io_fill, input int span);
        logic [31:0] noise;
        noise = $urandom;
        add_tick(1'b1, op, addr, wval, (io_fill == IoRandom) ? noise[19] : io_fill[0]);
        for (int i = 1; i < span; i++)
        begin
            noise = $urandom;
            add_tick(noise[0] & noise[20], noise[2:1], noise[10:3], noise[18:11],
                     (io_fill == IoRandom) ? noise[19] : io_fill[0]);
        end
    endtask

    function automatic int full_span(input rtc3w_pkg::op_t op);
        return (op == rtc3w_pkg::OP_BURST) ? 16 + 16 * BurstLen : 32;
    endfunction

    task automatic set_threshold(input logic [7:0] v);
        @(posedge clk);
        cfg_write_en <= 1'b1;
        cfg_write_data <= v;
        @(posedge clk);
        cfg_write_en <= 1'b0;
        ram_limit = v;
    endtask

    task automatic wait_drained;
        @(negedge clk);
        while (tick_queue.size() != 0 || req_valid || due_pins.size() != 0)
            @(negedge clk);
        repeat (3) @(posedge clk);
    endtask

    // tick driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid <= 1'b0;
            gap_left <= 0;
        end
        else if (!req_valid || req_ready)
        begin
            if (gap_left > 0)
            begin
                req_valid <= 1'b0;
                gap_left <= gap_left - 1;
            end
            else if (tick_queue.size() > 0)
            begin
                req <= tick_queue.pop_front();
                req_valid <= 1'b1;
                gap_left <= quiet_run ? 0 : $urandom_range(0, 10);
            end
            else
            begin
                req_valid <= 1'b0;
            end
        end
    end

    // response side stalls
    always @(posedge clk or negedge rst_n)
    begin : rx_side
        int pause;
        if (!rst_n)
        begin
            rsp_ready <= 1'b0;
            stall_left <= 0;
        end
        else if (stall_left > 0)
        begin
            rsp_ready <= 1'b0;
            stall_left <= stall_left - 1;
        end
        else if (rsp_valid && rsp_ready)
        begin
            pause = quiet_run ? 0 : $urandom_range(0, 10);
            rsp_ready <= (pause == 0);
            stall_left <= (pause == 0) ? 0 : pause - 1;
        end
        else
        begin
            rsp_ready <= 1'b1;
        end
    end

    // monitor
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (rsp_valid && rsp_ready)
            begin
                ticks_checked++;
                if (rsp.read_valid)
                    bytes_read++;
                if (due_pins.size() == 0)
                begin
                    $error("response transaction with nothing expected");
                    fail_count++;
                end
                else
                begin
                    rtc3w_pkg::rsp_t want;
                    want = due_pins.pop_front();
                    check_field("chip_enable", want.chip_enable, rsp.chip_enable);
                    check_field("serial_clock", want.serial_clock, rsp.serial_clock);
                    check_field("io_out", want.io_out, rsp.io_out);
                    check_field("io_drive", want.io_drive, rsp.io_drive);
                    check_field("read_value", want.read_value, rsp.read_value);
                    check_field("read_valid", want.read_valid, rsp.read_valid);
                    check_field("read_last", want.read_last, rsp.read_last);
                    check_field("busy_res", want.busy_res, rsp.busy_res);
                end
            end
            if (req_valid && req_ready)
                due_pins.push_back(bus_tick(req));
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        if (!rst_n || (req_valid && req_ready) || (rsp_valid && rsp_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QuietLimit)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial
    begin
        logic [7:0] limits [6];
        int queued;
        int pick;
        rtc3w_pkg::op_t op;
        logic [7:0] addr;
        logic [31:0] noise;

        limits = '{8'd0, 8'd255, 8'd1, 8'd128, 8'd0, 8'd0};
        limits[4] = $urandom_range(0, 255);
        limits[5] = $urandom_range(0, 255);

        // directed, threshold at its reset value
        add_transfer(rtc3w_pkg::OP_WRITE, 8'h00, 8'h00, IoRandom, 32);
        add_transfer(rtc3w_pkg::OP_WRITE, 8'h8e, 8'hff, IoRandom, 32);
        add_transfer(rtc3w_pkg::OP_WRITE, 8'hc0, 8'ha5, IoRandom, 32);
        add_transfer(rtc3w_pkg::OP_READ, 8'hbf, 8'h00, IoHigh, 32);
        add_transfer(rtc3w_pkg::OP_READ, 8'hff, 8'hff, IoLow, 32);
        add_tick(1'b1, OpUndefined, 8'h10, 8'h55, 1'b1);
        add_tick(1'b0, rtc3w_pkg::OP_READ, 8'h10, 8'h55, 1'b0);
        add_transfer(rtc3w_pkg::OP_BURST, 8'hbe, 8'h3c, IoRandom,
                     full_span(rtc3w_pkg::OP_BURST));

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        wait_drained();

        for (int p = 0; p < 6; p++)
        begin
            set_threshold(limits[p]);
            quiet_run = p[0];
            queued = 0;
            while (queued < 80)
            begin
                pick = $urandom_range(0, 9);
                if (pick == 0)
                begin
                    repeat ($urandom_range(1, 4)) add_noise_tick();
                    queued += 2;
                end
                else
                begin
                    op = (pick <= 3) ? rtc3w_pkg::OP_WRITE
                       : (pick <= 6) ? rtc3w_pkg::OP_READ : rtc3w_pkg::OP_BURST;
                    noise = $urandom;
                    case (noise[1:0])
                        2'd0: addr = ram_limit;
                        2'd1: addr = ram_limit - 8'd1;
                        default: addr = noise[9:2];
                    endcase
                    // now and then a transfer cut short, so the next start lands mid-way
                    add_transfer(op, addr, noise[17:10], IoRandom,
                                 (noise[21:18] == 4'd0) ? $urandom_range(1, full_span(op) - 1)
                                                        : full_span(op));
                    queued += full_span(op);
                end
            end
            wait_drained();
        end

        $display("checked %0d bus ticks: %0d transfers started, %0d bytes read back",
                 ticks_checked, transfers_started, bytes_read);
        $display("thresholds 192, 0, 255, 1, 128 and two random values, with and without stalls");
        if (fail_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
